/* hw/rtl/mlqs_pkg.sv */
// ---------------------------------------------------------------------------
// Multilevel quota queue scheduler package
// Shared widths, codes and types of the scheduler's modules.
// ---------------------------------------------------------------------------
package mlqs_pkg;

   localparam int NUM_LEVELS_DEFAULT  = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int ID_W     = 8;
   localparam int LEVEL_W  = 2;
   localparam int STATUS_W = 2;
   localparam int QUOTA_W  = 8;

   localparam logic [QUOTA_W-1:0] BASE_QUOTA_RESET = 8'd8;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   // Access strobes from the control path to the task memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

/* hw/rtl/mlqs_fifo_mem.sv */
// ---------------------------------------------------------------------------
// Task identifier memory
// Single-port synchronous RAM holding every level's FIFO; registered read.
// ---------------------------------------------------------------------------
module mlqs_fifo_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                      clock,
   input  mlqs_pkg::mem_cmd_type     cmd,
   input  logic [ADDR_W-1:0]         addr,
   input  logic [mlqs_pkg::ID_W-1:0] wr_data,
   output logic [mlqs_pkg::ID_W-1:0] rd_data
);
   import mlqs_pkg::*;

   logic [ID_W-1:0] fifo_mem [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         fifo_mem[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= fifo_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mlqs_ctrl.sv */
// ---------------------------------------------------------------------------
// Scheduler control
// Per-level pointers, fill counts and quotas, the level scan, the memory
// access and the result register.
// ---------------------------------------------------------------------------
module mlqs_ctrl #(
   parameter int NUM_LEVELS  = 4,
   parameter int QUEUE_DEPTH = 16,
   parameter int ADDR_W      = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [mlqs_pkg::ID_W-1:0]     req_task_id,
   input  logic [mlqs_pkg::LEVEL_W-1:0]  req_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mlqs_pkg::STATUS_W-1:0] rsp_status,
   output logic [mlqs_pkg::ID_W-1:0]     rsp_served_id,
   output logic [mlqs_pkg::LEVEL_W-1:0]  rsp_served_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mlqs_pkg::QUOTA_W-1:0]  csr_wdata,
   output mlqs_pkg::mem_cmd_type         mem_cmd,
   output logic [ADDR_W-1:0]             mem_addr,
   output logic [mlqs_pkg::ID_W-1:0]     mem_wr_data,
   input  logic [mlqs_pkg::ID_W-1:0]     mem_rd_data
);
   import mlqs_pkg::*;

   localparam int LVL_W = $clog2(NUM_LEVELS);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [QUOTA_W-1:0] base_quota_ff, base_quota_in;
   logic [PTR_W-1:0]   head_ff [NUM_LEVELS];
   logic [PTR_W-1:0]   head_in [NUM_LEVELS];
   logic [PTR_W-1:0]   tail_ff [NUM_LEVELS];
   logic [PTR_W-1:0]   tail_in [NUM_LEVELS];
   logic [CNT_W-1:0]   fill_ff [NUM_LEVELS];
   logic [CNT_W-1:0]   fill_in [NUM_LEVELS];
   logic [QUOTA_W-1:0] quota_ff [NUM_LEVELS];
   logic [QUOTA_W-1:0] quota_in [NUM_LEVELS];

   logic                busy_ff, busy_in;
   logic [LEVEL_W-1:0]  pend_level_ff, pend_level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_served_id_ff, rsp_served_id_in;
   logic [LEVEL_W-1:0]  rsp_served_level_ff, rsp_served_level_in;

   logic                  acc, is_deq, lvl_ok, enq_ok, any_ready;
   logic                  need_reload;
   logic [LVL_W-1:0]      in_lvl, scan_start, first, second_start, second, pick;
   logic [NUM_LEVELS-1:0] nonempty, full_mask, zero_quota;

   // Saturating reload value of level k.
   function automatic logic [QUOTA_W-1:0] reload(input logic [QUOTA_W-1:0] base,
                                                 input int k);
      logic [QUOTA_W-1:0] r;
      r = '0;
      if (int'(base) >= k) begin
         r = QUOTA_W'(int'(base) - k);
      end
      return r;
   endfunction

   // First set bit of mask at or after start, wrapping around.
   function automatic logic [LVL_W-1:0] scan(input logic [NUM_LEVELS-1:0] mask,
                                             input logic [LVL_W-1:0] start);
      logic [LVL_W-1:0]      idx_hi, idx_lo;
      logic [NUM_LEVELS-1:0] hi;
      idx_hi = '0;
      idx_lo = '0;
      for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
         hi[k] = mask[k] && (LVL_W'(k) >= start);
         if (hi[k]) begin
            idx_hi = LVL_W'(k);
         end
         if (mask[k]) begin
            idx_lo = LVL_W'(k);
         end
      end
      return (|hi) ? idx_hi : idx_lo;
   endfunction

   always_comb begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
         nonempty[k]   = fill_ff[k] != '0;
         full_mask[k]  = fill_ff[k] == CNT_W'(QUEUE_DEPTH);
         zero_quota[k] = quota_ff[k] == '0;
      end
   end

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign acc       = req_valid && req_ready;
   assign is_deq    = req_mode == MODE_DEQUEUE;
   assign lvl_ok    = int'(req_level) < NUM_LEVELS;
   assign in_lvl    = LVL_W'(req_level);
   assign enq_ok    = lvl_ok && !full_mask[in_lvl];
   assign any_ready = |nonempty;

   // A level with spent quota is reloaded and passes service on; the second
   // scan wraps back to that same level when no other level holds a task.
   assign scan_start   = lvl_ok ? in_lvl : '0;
   assign first        = scan(nonempty, scan_start);
   assign need_reload  = zero_quota[first];
   assign second_start = (first == LVL_W'(NUM_LEVELS - 1)) ? '0 : first + 1'b1;
   assign second       = scan(nonempty, second_start);
   assign pick         = need_reload ? second : first;

   assign mem_cmd.wr_en = acc && !is_deq && enq_ok;
   assign mem_cmd.rd_en = acc && is_deq && any_ready;
   assign mem_addr      = is_deq
                          ? ADDR_W'(ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[pick]))
                          : ADDR_W'(ADDR_W'(in_lvl) * ADDR_W'(QUEUE_DEPTH)
                                    + ADDR_W'(tail_ff[in_lvl]));
   assign mem_wr_data   = req_task_id;

   always_comb begin
      logic [QUOTA_W-1:0] q;
      base_quota_in = csr_valid ? csr_wdata : base_quota_ff;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         head_in[k]  = head_ff[k];
         tail_in[k]  = tail_ff[k];
         fill_in[k]  = fill_ff[k];
         quota_in[k] = quota_ff[k];
         q           = quota_ff[k];
         if (mem_cmd.wr_en && in_lvl == LVL_W'(k)) begin
            tail_in[k] = (tail_ff[k] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff[k] + 1'b1;
            fill_in[k] = fill_ff[k] + 1'b1;
         end
         if (mem_cmd.rd_en) begin
            if (need_reload && first == LVL_W'(k)) begin
               q = reload(base_quota_ff, k);
            end
            if (pick == LVL_W'(k)) begin
               if (q != '0) begin
                  q = q - 1'b1;
               end
               head_in[k] = (head_ff[k] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff[k] + 1'b1;
               fill_in[k] = fill_ff[k] - 1'b1;
            end
            quota_in[k] = q;
         end
      end
   end

   always_comb begin
      busy_in             = 1'b0;
      pend_level_in       = pend_level_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_status_in       = rsp_status_ff;
      rsp_served_id_in    = rsp_served_id_ff;
      rsp_served_level_in = rsp_served_level_ff;
      if (busy_ff) begin
         // The popped identifier arrives from the memory in the cycle after the read.
         rsp_valid_in        = 1'b1;
         rsp_status_in       = STATUS_DEQUEUED;
         rsp_served_id_in    = mem_rd_data;
         rsp_served_level_in = pend_level_ff;
      end else if (acc) begin
         rsp_served_id_in    = '0;
         rsp_served_level_in = '0;
         if (!is_deq) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = enq_ok ? STATUS_ENQUEUED : STATUS_FULL;
         end else if (any_ready) begin
            busy_in       = 1'b1;
            pend_level_in = LEVEL_W'(pick);
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_quota_ff <= BASE_QUOTA_RESET;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < NUM_LEVELS; k++) begin
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            fill_ff[k]  <= '0;
            quota_ff[k] <= reload(BASE_QUOTA_RESET, k);
         end
      end else begin
         base_quota_ff <= base_quota_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int k = 0; k < NUM_LEVELS; k++) begin
            head_ff[k]  <= head_in[k];
            tail_ff[k]  <= tail_in[k];
            fill_ff[k]  <= fill_in[k];
            quota_ff[k] <= quota_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_level_ff       <= pend_level_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_served_id_ff    <= rsp_served_id_in;
      rsp_served_level_ff <= rsp_served_level_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_served_id    = rsp_served_id_ff;
   assign rsp_served_level = rsp_served_level_ff;

   a_deq_read: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.rd_en |=> busy_ff && !req_ready)
      else $error("dequeue read did not block the input");

   a_deq_result: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff && rsp_status_ff == STATUS_DEQUEUED)
      else $error("dequeue result not loaded after the memory read");

   a_enq_result: assert property (@(posedge clock) disable iff (reset)
      (acc && !is_deq) |=> rsp_valid_ff
                           && (rsp_status_ff == STATUS_ENQUEUED || rsp_status_ff == STATUS_FULL))
      else $error("enqueue result missing");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_DEQUEUED)
         |-> rsp_served_id_ff == '0 && rsp_served_level_ff == '0)
      else $error("non-dequeue result carries a served task");

endmodule

/* hw/rtl/multilevel_quota_queue_scheduler.sv */
// ---------------------------------------------------------------------------
// Multilevel quota queue scheduler
// Per-level task FIFOs with weighted round-robin service by level quotas.
// ---------------------------------------------------------------------------
// Requests enter on the req_ channel: mode 0 appends req_task_id to the FIFO
// of req_level, mode 1 pops the next task, scanning upward from req_level.
// Every request yields one item on the rsp_ channel with a status, the served
// identifier and its level. The csr_ channel writes base_quota; level k may
// be served base_quota - k times in a row before it yields to the next level.
// All FIFOs share one single-port RAM with a registered read. An enqueue's
// result is visible the cycle after acceptance. For a dequeue, the scan and
// the pointer update happen at acceptance, the RAM read register then feeds
// the result register, and the request channel is held off during that read.
// Sustained rate is one enqueue per cycle while the receiver takes every
// result; a new dequeue is not accepted until the last one's read has filled
// the result register. A stalled receiver holds the result register, and
// req_ready stays low until the pending item is taken. Reset empties all
// FIFOs, sets base_quota to 8 and loads each level's quota; it needs no
// clearing pass.
// ---------------------------------------------------------------------------
module multilevel_quota_queue_scheduler #(
   parameter int NUM_LEVELS  = mlqs_pkg::NUM_LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [mlqs_pkg::ID_W-1:0]     req_task_id,
   input  logic [mlqs_pkg::LEVEL_W-1:0]  req_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mlqs_pkg::STATUS_W-1:0] rsp_status,
   output logic [mlqs_pkg::ID_W-1:0]     rsp_served_id,
   output logic [mlqs_pkg::LEVEL_W-1:0]  rsp_served_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mlqs_pkg::QUOTA_W-1:0]  csr_wdata
);
   import mlqs_pkg::*;

   localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   mem_cmd_type       mem_cmd;
   logic [ADDR_W-1:0] mem_addr;
   logic [ID_W-1:0]   mem_wr_data;
   logic [ID_W-1:0]   mem_rd_data;

   mlqs_ctrl #(
      .NUM_LEVELS  (NUM_LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_task_id      (req_task_id),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_served_id    (rsp_served_id),
      .rsp_served_level (rsp_served_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .mem_cmd          (mem_cmd),
      .mem_addr         (mem_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_data      (mem_rd_data)
   );

   mlqs_fifo_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_fifo_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
